>>> design/pzts_pkg.sv
// Shared types, constants and helper functions for the pan/zoom target smoother.
// Used by pzts_blend and pan_zoom_target_smoother; depends on nothing else.
`default_nettype none

package pzts_pkg;

  // Fixed-point formats
  localparam int POS_FRAC_BITS   = 8;
  localparam int ALPHA_FRAC_BITS = 16;

  // Field widths
  localparam int POS_W       = 24;
  localparam int ZOOM_W      = 16;
  localparam int ZVAL_W      = 17;
  localparam int BOUND_W     = 16;
  localparam int ALPHA_W     = ALPHA_FRAC_BITS + 1;
  localparam int FUNC_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  // Target sums (target plus offset) before clamping
  localparam int RAW_W = POS_W + 2;
  // Bound scaling is done at this width, then saturated
  localparam int SCL_W = BOUND_W + POS_FRAC_BITS + 1;

  // Stream word widths
  localparam int IN_DATA_BITS   = 2 * POS_W + ZVAL_W;
  localparam int IN_TDATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W     = FUNC_W;
  localparam int OUT_DATA_BITS  = 4 * POS_W + 2 * ZOOM_W;
  localparam int OUT_TDATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;

  localparam logic signed [SCL_W-1:0] POS_MAX_S = SCL_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
  localparam logic signed [SCL_W-1:0] POS_MIN_S = SCL_W'(-(64'sd1 <<< (POS_W - 1)));

  // Event codes carried in tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_SET_CENTRE   = 3'd0,
    FN_NUDGE_CENTRE = 3'd1,
    FN_SET_ZOOM     = 3'd2,
    FN_NUDGE_ZOOM   = 3'd3,
    FN_SNAP_ALL     = 3'd4,
    FN_SNAP_CENTRE  = 3'd5,
    FN_TICK         = 3'd6
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CI_ZOOM_LO      = 3'd0,
    CI_ZOOM_HI      = 3'd1,
    CI_BOUND_LEFT   = 3'd2,
    CI_BOUND_RIGHT  = 3'd3,
    CI_BOUND_TOP    = 3'd4,
    CI_BOUND_BOTTOM = 3'd5,
    CI_POS_ALPHA    = 3'd6,
    CI_ZOOM_ALPHA   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        [ZOOM_W-1:0]  zoom_lo;
    logic        [ZOOM_W-1:0]  zoom_hi;
    logic signed [BOUND_W-1:0] bound_left;
    logic signed [BOUND_W-1:0] bound_right;
    logic signed [BOUND_W-1:0] bound_top;
    logic signed [BOUND_W-1:0] bound_bottom;
    logic        [ALPHA_W-1:0] pos_alpha;
    logic        [ALPHA_W-1:0] zoom_alpha;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    zoom_lo:      ZOOM_W'(256),
    zoom_hi:      ZOOM_W'(8192),
    bound_left:   BOUND_W'(0),
    bound_right:  BOUND_W'(1919),
    bound_top:    BOUND_W'(0),
    bound_bottom: BOUND_W'(1079),
    pos_alpha:    ALPHA_ONE,
    zoom_alpha:   ALPHA_ONE
  };

  localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(256);

  // Whole-pixel bound to fixed point, saturated to the position range
  function automatic logic signed [POS_W-1:0] scale_bound(input logic signed [BOUND_W-1:0] b);
    logic signed [SCL_W-1:0] s;
    logic signed [SCL_W-1:0] r;
    s = SCL_W'(b) <<< POS_FRAC_BITS;
    if (s < POS_MIN_S) begin
      r = POS_MIN_S;
    end else if (s > POS_MAX_S) begin
      r = POS_MAX_S;
    end else begin
      r = s;
    end
    return r[POS_W-1:0];
  endfunction

  // Low limit wins when the value is below it, otherwise the high limit caps it
  function automatic logic signed [POS_W-1:0] clamp_sat(input logic signed [RAW_W-1:0] v,
                                                        input logic signed [POS_W-1:0] lo,
                                                        input logic signed [POS_W-1:0] hi);
    logic signed [RAW_W-1:0] lo_x;
    logic signed [RAW_W-1:0] hi_x;
    logic signed [RAW_W-1:0] r;
    lo_x = RAW_W'(lo);
    hi_x = RAW_W'(hi);
    if (v < lo_x) begin
      r = lo_x;
    end else if (v > hi_x) begin
      r = hi_x;
    end else begin
      r = v;
    end
    return r[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/pzts_blend.sv
// One smoothing lane: moves a current value toward its target by alpha.
// Depends on pzts_pkg for widths and the alpha format.
`default_nettype none

module pzts_blend
  import pzts_pkg::*;
(
  input  wire logic signed [POS_W-1:0]   cur,
  input  wire logic signed [POS_W-1:0]   tgt,
  input  wire logic        [ALPHA_W-1:0] alpha,
  output logic signed [POS_W-1:0]        nxt
);

  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W;
  localparam int SUM_W  = POS_W + 2;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] mag;
  logic        [ALPHA_W-1:0] alpha_eff;
  logic        [PROD_W-1:0]  prod;
  logic        [PROD_W-1:0]  rnd;
  logic        [DIFF_W-1:0]  step;
  logic signed [SUM_W-1:0]   sum;

  // Magnitude of the error, scaled by alpha with round half away from zero
  always_comb begin
    diff      = DIFF_W'(tgt) - DIFF_W'(cur);
    mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    prod      = PROD_W'(mag) * PROD_W'(alpha_eff);
    rnd       = prod + (PROD_W'(1) << (ALPHA_FRAC_BITS - 1));
    step      = rnd[ALPHA_FRAC_BITS +: DIFF_W];
    if (diff[DIFF_W-1]) begin
      sum = SUM_W'(cur) - $signed(SUM_W'(step));
    end else begin
      sum = SUM_W'(cur) + $signed(SUM_W'(step));
    end
    // The step never overshoots the target, so the result stays in range
    nxt = sum[POS_W-1:0];
  end

endmodule

`default_nettype wire

>>> design/pan_zoom_target_smoother.sv
// Pan/zoom target smoother: an accepted input word goes to the input register, then
// to the state registers that also serve as the result word. Throughput one word per
// clock while no config write is pending and the result is not stalled; the path
// between registers is one clamp or one 25x17 multiply-add per lane. Config writes
// take effect, with target clamping, at the accepting edge. rst_n (synchronous, active
// low) restores config defaults, zero centre, zoom 1.0, and empties the pipeline.
`default_nettype none

module pan_zoom_target_smoother
  import pzts_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Input stream
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,   // value_x, value_y, zoom_value
  input  wire logic [IN_TUSER_W-1:0]   in_tuser,   // func
  // Result stream
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,  // centre_x, centre_y, zoom,
                                                   // goal_x, goal_y, goal_zoom
  // Config write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  // Handshake and pipeline control
  logic in_fire, cfg_fire, out_free, s2_fire;
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;

  // Input register
  logic [FUNC_W-1:0]        s1_func_r;
  logic signed [POS_W-1:0]  s1_vx_r, s1_vy_r;
  logic signed [ZVAL_W-1:0] s1_vz_r;
  func_t                    fn;

  // Config and smoothing state
  cfg_regs_t cfg_r, cfg_nxt;
  logic signed [POS_W-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [POS_W-1:0] cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt;
  logic [ZOOM_W-1:0]       cur_z_r, tgt_z_r, cur_z_nxt, tgt_z_nxt;

  // Clamp datapath
  logic signed [RAW_W-1:0] raw_x, raw_y, raw_z;
  logic signed [POS_W-1:0] cl_x, cl_y, cl_z;
  logic                    do_clamp;

  // Blend lanes
  logic signed [POS_W-1:0] bl_x, bl_y, bl_z;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign out_free  = ~out_v_r | out_tready;
  assign s2_fire   = s1_v_r & out_free;
  assign in_tready = (~s1_v_r | out_free) & ~cfg_valid;
  assign in_fire   = in_tvalid & in_tready;
  assign fn        = func_t'(s1_func_r);

  // Pipeline valid bits
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s2_fire) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s2_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_fire) begin
      unique case (cfg_idx_t'(cfg_index))
        CI_ZOOM_LO:      cfg_nxt.zoom_lo      = cfg_data[ZOOM_W-1:0];
        CI_ZOOM_HI:      cfg_nxt.zoom_hi      = cfg_data[ZOOM_W-1:0];
        CI_BOUND_LEFT:   cfg_nxt.bound_left   = cfg_data[BOUND_W-1:0];
        CI_BOUND_RIGHT:  cfg_nxt.bound_right  = cfg_data[BOUND_W-1:0];
        CI_BOUND_TOP:    cfg_nxt.bound_top    = cfg_data[BOUND_W-1:0];
        CI_BOUND_BOTTOM: cfg_nxt.bound_bottom = cfg_data[BOUND_W-1:0];
        CI_POS_ALPHA:    cfg_nxt.pos_alpha    = cfg_data[ALPHA_W-1:0];
        CI_ZOOM_ALPHA:   cfg_nxt.zoom_alpha   = cfg_data[ALPHA_W-1:0];
      endcase
    end
  end

  // Raw targets: set or nudge, then clamp all three against the new limits
  always_comb begin
    raw_x    = RAW_W'(tgt_x_r);
    raw_y    = RAW_W'(tgt_y_r);
    raw_z    = RAW_W'(tgt_z_r);
    do_clamp = cfg_fire;
    if (s2_fire) begin
      unique case (fn)
        FN_SET_CENTRE: begin
          raw_x    = RAW_W'(s1_vx_r);
          raw_y    = RAW_W'(s1_vy_r);
          do_clamp = 1'b1;
        end
        FN_NUDGE_CENTRE: begin
          raw_x    = RAW_W'(tgt_x_r) + RAW_W'(s1_vx_r);
          raw_y    = RAW_W'(tgt_y_r) + RAW_W'(s1_vy_r);
          do_clamp = 1'b1;
        end
        FN_SET_ZOOM: begin
          raw_z    = RAW_W'(s1_vz_r);
          do_clamp = 1'b1;
        end
        FN_NUDGE_ZOOM: begin
          raw_z    = RAW_W'(tgt_z_r) + RAW_W'(s1_vz_r);
          do_clamp = 1'b1;
        end
        default: ;
      endcase
    end
    cl_x = clamp_sat(raw_x, scale_bound(cfg_nxt.bound_left), scale_bound(cfg_nxt.bound_right));
    cl_y = clamp_sat(raw_y, scale_bound(cfg_nxt.bound_top), scale_bound(cfg_nxt.bound_bottom));
    cl_z = clamp_sat(raw_z, POS_W'(cfg_nxt.zoom_lo), POS_W'(cfg_nxt.zoom_hi));
    tgt_x_nxt = do_clamp ? cl_x : tgt_x_r;
    tgt_y_nxt = do_clamp ? cl_y : tgt_y_r;
    tgt_z_nxt = do_clamp ? cl_z[ZOOM_W-1:0] : tgt_z_r;
  end

  // Smoothing lanes
  pzts_blend u_blend_x (
    .cur   (cur_x_r),
    .tgt   (tgt_x_r),
    .alpha (cfg_r.pos_alpha),
    .nxt   (bl_x)
  );

  pzts_blend u_blend_y (
    .cur   (cur_y_r),
    .tgt   (tgt_y_r),
    .alpha (cfg_r.pos_alpha),
    .nxt   (bl_y)
  );

  pzts_blend u_blend_z (
    .cur   (POS_W'(cur_z_r)),
    .tgt   (POS_W'(tgt_z_r)),
    .alpha (cfg_r.zoom_alpha),
    .nxt   (bl_z)
  );

  // Current values: snap or tick
  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    cur_z_nxt = cur_z_r;
    if (s2_fire) begin
      unique case (fn)
        FN_SNAP_ALL: begin
          cur_x_nxt = tgt_x_r;
          cur_y_nxt = tgt_y_r;
          cur_z_nxt = tgt_z_r;
        end
        FN_SNAP_CENTRE: begin
          cur_x_nxt = tgt_x_r;
          cur_y_nxt = tgt_y_r;
        end
        FN_TICK: begin
          cur_x_nxt = bl_x;
          cur_y_nxt = bl_y;
          cur_z_nxt = bl_z[ZOOM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cfg_r   <= CFG_RESET;
      cur_x_r <= '0;
      cur_y_r <= '0;
      cur_z_r <= ZOOM_RESET;
      tgt_x_r <= '0;
      tgt_y_r <= '0;
      tgt_z_r <= ZOOM_RESET;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      cfg_r   <= cfg_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      cur_z_r <= cur_z_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      tgt_z_r <= tgt_z_nxt;
    end
  end

  // Input word register (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_vx_r   <= in_tdata[0 +: POS_W];
      s1_vy_r   <= in_tdata[POS_W +: POS_W];
      s1_vz_r   <= in_tdata[2*POS_W +: ZVAL_W];
      s1_func_r <= in_tuser;
    end
  end

  // Result word: current values hold while the result is stalled; a config write can still re-clamp the targets
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({tgt_z_r, tgt_y_r, tgt_x_r, cur_z_r, cur_y_r, cur_x_r});

  // Checks
  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !in_tready)
    else $error("input accepted during a config write");

  a_snap_all: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && !cfg_fire && fn == FN_SNAP_ALL) |=>
      (cur_x_r == tgt_x_r && cur_y_r == tgt_y_r && cur_z_r == tgt_z_r))
    else $error("snap all left a current value off target");

  a_tick_full_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && !cfg_fire && fn == FN_TICK &&
     cfg_r.pos_alpha >= ALPHA_ONE && cfg_r.zoom_alpha >= ALPHA_ONE) |=>
      (cur_x_r == tgt_x_r && cur_y_r == tgt_y_r && cur_z_r == tgt_z_r))
    else $error("tick at full alpha did not reach the target");

  a_targets_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !s2_fire && !cfg_fire) |=>
      ($stable(tgt_x_r) && $stable(tgt_y_r) && $stable(tgt_z_r)))
    else $error("target changed without an event or config write");

  a_zoom_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && !cfg_fire && (fn == FN_SET_ZOOM || fn == FN_NUDGE_ZOOM) &&
     cfg_r.zoom_lo <= cfg_r.zoom_hi) |=>
      (tgt_z_r >= cfg_r.zoom_lo && tgt_z_r <= cfg_r.zoom_hi))
    else $error("zoom target outside its limits");

endmodule

`default_nettype wire
